[sv/tlq_pkg.sv]
// ============================================================================
// tlq_pkg - thread linked queue shared definitions
// Request and status codes, beat layouts and default sizing.
// ============================================================================
package tlq_pkg;

    localparam int MAX_THREADS_DEF = 32;

    // beat layouts
    localparam int REQ_W    = 3;
    localparam int TID_W    = 5;
    localparam int CNT_OUT_W = 6;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_POP    = 3'd3,
        REQ_QUERY  = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_BAD_MEMBER = 2'd2
    } status_t;

endpackage

[sv/thread_linked_queue_unit.sv]
// ============================================================================
// thread_linked_queue_unit - ordered queue of thread numbers
// Doubly linked list in prev/next link memories with head, tail, count and
// one membership flop per thread.
// ============================================================================
// An input beat is registered together with the link memory words it needs,
// and the execute stage then resolves the operation, updates head, tail,
// count and membership and loads the output register that offers the result.
// While results drain, a new beat is taken every cycle but for the stall
// below. Each link memory has a single write port: an insert before a thread
// other than the head needs a second write to both memories in the cycle
// after it resolves, so no beat is taken in the cycle the insert resolves nor
// in the cycle of that second write. The link memories need no clearing
// after reset; the membership flops reset to empty.
module thread_linked_queue_unit #(
    parameter int MAX_THREADS = tlq_pkg::MAX_THREADS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [2:0] req_type, [7:3] thread_id, [12:8] target_thread, [15:13] zero
    input  logic [tlq_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [4:0] popped_thread, [5] found, [11:6] queue_count, [13:12] status,
    // [15:14] zero
    output logic [tlq_pkg::OUT_W-1:0] m_tdata
);

    localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    // link memories, only entries of members are ever used
    logic [IDX_W-1:0] prev_mem [MAX_THREADS];
    logic [IDX_W-1:0] next_mem [MAX_THREADS];

    logic [MAX_THREADS-1:0] member_reg, member_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // execute stage
    logic                     ex_valid_reg;
    tlq_pkg::req_t            ex_req_reg;
    logic [tlq_pkg::TID_W-1:0] ex_th_reg, ex_tg_reg;
    logic [IDX_W-1:0]         rd_prev_reg, rd_next_reg;

    // second half of a mid-list insert
    logic             p2_valid_reg;
    logic [IDX_W-1:0] p2_th_reg, p2_tg_reg, p2_p_reg;

    logic                      out_valid_reg;
    logic [tlq_pkg::OUT_W-1:0] out_data_reg;

    logic s_accept, ex_fire, p2_set;

    // input decode
    tlq_pkg::req_t             in_req;
    logic [tlq_pkg::TID_W-1:0] in_th, in_tg;
    logic [IDX_W-1:0]          in_tg_idx, rd_next_addr;

    // memory write ports
    logic             prev_we, next_we;
    logic [IDX_W-1:0] prev_wa, prev_wd, next_wa, next_wd;

    // execute decode
    logic [IDX_W-1:0] th_idx, tg_idx, u_idx;
    logic             th_slot, tg_slot, th_mem, tg_mem, empty;
    logic             p_nil, n_nil;
    logic             ex_ok;
    logic [tlq_pkg::TID_W-1:0]  res_popped;
    logic                       res_found;
    tlq_pkg::status_t           res_status;
    logic [tlq_pkg::OUT_W-1:0]  res_data;

    assign in_req    = tlq_pkg::req_t'(s_tdata[2:0]);
    assign in_th     = s_tdata[7:3];
    assign in_tg     = s_tdata[12:8];
    assign in_tg_idx = IDX_W'(in_tg);
    // a pop reads the successor of the head as it stands after this edge
    assign rd_next_addr = (in_req == tlq_pkg::REQ_POP) ? head_next : in_tg_idx;

    assign ex_fire  = ex_valid_reg && !p2_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p2_valid_reg && !p2_set && (!ex_valid_reg || ex_fire);
    assign s_accept = s_tvalid && s_tready;

    assign th_idx  = IDX_W'(ex_th_reg);
    assign tg_idx  = IDX_W'(ex_tg_reg);
    assign th_slot = 32'(ex_th_reg) < 32'(MAX_THREADS);
    assign tg_slot = 32'(ex_tg_reg) < 32'(MAX_THREADS);
    assign th_mem  = th_slot && member_reg[th_idx];
    assign tg_mem  = tg_slot && member_reg[tg_idx];
    assign empty   = (cnt_reg == '0);
    assign u_idx   = (ex_req_reg == tlq_pkg::REQ_POP) ? head_reg : tg_idx;
    // head has no predecessor and tail no successor, whatever the links hold
    assign p_nil   = (u_idx == head_reg);
    assign n_nil   = (u_idx == tail_reg);

    always_comb
    begin
        ex_ok       = 1'b0;
        res_popped  = '0;
        res_found   = 1'b0;
        res_status  = tlq_pkg::ST_OK;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        member_next = member_reg;
        prev_we     = 1'b0;
        prev_wa     = p2_tg_reg;
        prev_wd     = p2_th_reg;
        next_we     = 1'b0;
        next_wa     = p2_p_reg;
        next_wd     = p2_th_reg;
        p2_set      = 1'b0;

        if (p2_valid_reg)
        begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end
        else if (ex_fire)
        begin
            unique case (ex_req_reg) inside
                tlq_pkg::REQ_PUSH:
                begin
                    if (!th_slot || th_mem)
                        res_status = tlq_pkg::ST_BAD_MEMBER;
                    else
                    begin
                        ex_ok = 1'b1;
                        if (empty)
                            head_next = th_idx;
                        else
                        begin
                            prev_we = 1'b1;
                            prev_wa = th_idx;
                            prev_wd = tail_reg;
                            next_we = 1'b1;
                            next_wa = tail_reg;
                            next_wd = th_idx;
                        end
                        tail_next           = th_idx;
                        member_next[th_idx] = 1'b1;
                        cnt_next            = cnt_reg + CNT_W'(1);
                    end
                end
                tlq_pkg::REQ_INSERT:
                begin
                    if (!tg_mem || !th_slot || th_mem)
                        res_status = tlq_pkg::ST_BAD_MEMBER;
                    else
                    begin
                        ex_ok   = 1'b1;
                        next_we = 1'b1;
                        next_wa = th_idx;
                        next_wd = tg_idx;
                        prev_we = 1'b1;
                        if (p_nil)
                        begin
                            prev_wa   = tg_idx;
                            prev_wd   = th_idx;
                            head_next = th_idx;
                        end
                        else
                        begin
                            // prev[tg] and next[p] follow in the next cycle
                            prev_wa = th_idx;
                            prev_wd = rd_prev_reg;
                            p2_set  = 1'b1;
                        end
                        member_next[th_idx] = 1'b1;
                        cnt_next            = cnt_reg + CNT_W'(1);
                    end
                end
                tlq_pkg::REQ_DELETE, tlq_pkg::REQ_POP:
                begin
                    if (ex_req_reg == tlq_pkg::REQ_DELETE && !tg_mem)
                        res_status = tlq_pkg::ST_BAD_MEMBER;
                    else if (ex_req_reg == tlq_pkg::REQ_POP && empty)
                        res_status = tlq_pkg::ST_EMPTY;
                    else
                    begin
                        ex_ok = 1'b1;
                        if (ex_req_reg == tlq_pkg::REQ_POP)
                        begin
                            res_popped = tlq_pkg::TID_W'(head_reg);
                            res_found  = 1'b1;
                        end
                        if (p_nil)
                            head_next = rd_next_reg;
                        if (n_nil)
                            tail_next = rd_prev_reg;
                        if (!p_nil && !n_nil)
                        begin
                            next_we = 1'b1;
                            next_wa = rd_prev_reg;
                            next_wd = rd_next_reg;
                            prev_we = 1'b1;
                            prev_wa = rd_next_reg;
                            prev_wd = rd_prev_reg;
                        end
                        member_next[u_idx] = 1'b0;
                        cnt_next           = cnt_reg - CNT_W'(1);
                    end
                end
                tlq_pkg::REQ_QUERY:
                begin
                    res_found = th_mem;
                end
                tlq_pkg::REQ_CLEAR:
                begin
                    member_next = '0;
                    cnt_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_data = {2'b00, res_status, tlq_pkg::CNT_OUT_W'(cnt_next), res_found,
                       res_popped};

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (s_accept)
        begin
            // write-first read so a beat sees the update made on the same edge
            if (prev_we && prev_wa == in_tg_idx)
                rd_prev_reg <= prev_wd;
            else
                rd_prev_reg <= prev_mem[in_tg_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (s_accept)
        begin
            if (next_we && next_wa == rd_next_addr)
                rd_next_reg <= next_wd;
            else
                rd_next_reg <= next_mem[rd_next_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ex_req_reg <= in_req;
            ex_th_reg  <= in_th;
            ex_tg_reg  <= in_tg;
        end
        if (p2_set)
        begin
            p2_th_reg <= th_idx;
            p2_tg_reg <= tg_idx;
            p2_p_reg  <= rd_prev_reg;
        end
        if (ex_fire)
            out_data_reg <= res_data;
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            member_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s_accept)
                ex_valid_reg <= 1'b1;
            else if (ex_fire)
                ex_valid_reg <= 1'b0;
            p2_valid_reg <= p2_set;
            if (ex_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            member_reg <= member_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // no beat is taken while the second insert write is pending
    assert property (@(posedge clk) disable iff (!rst_n) p2_valid_reg |-> !s_accept)
        else $error("beat accepted during pending link write");

    // the pending write lasts exactly one cycle
    assert property (@(posedge clk) disable iff (!rst_n) p2_valid_reg |=> !p2_valid_reg)
        else $error("pending link write held too long");

    // count tracks the membership flops
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(member_reg) == int'(cnt_reg))
        else $error("queue count differs from membership");

    // a step never leaves an unread result overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !ex_fire)
        else $error("result overwritten while stalled");

    // a pushed or inserted thread is a member afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (ex_ok && (ex_req_reg == tlq_pkg::REQ_PUSH || ex_req_reg == tlq_pkg::REQ_INSERT))
        |=> member_reg[$past(th_idx)])
        else $error("added thread not marked as member");
`endif

endmodule
